// File: rtl/htfd_pkg.sv
// ----------------------------------------------------------------------------
// htfd_pkg
// Shared types, constants and the CRC-8 helper of the humidity and
// temperature frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package htfd_pkg;

  // crc-8 of each measurement word
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // byte positions inside one frame
  localparam logic [2:0] POS_TEMP_MSB = 3'd0;
  localparam logic [2:0] POS_TEMP_LSB = 3'd1;
  localparam logic [2:0] POS_TEMP_CRC = 3'd2;
  localparam logic [2:0] POS_HUM_MSB  = 3'd3;
  localparam logic [2:0] POS_HUM_LSB  = 3'd4;
  localparam logic [2:0] POS_HUM_CRC  = 3'd5;

  // conversion scale factors, in hundredths
  localparam logic [14:0] TEMP_SPAN   = 15'd17500;
  localparam logic [15:0] TEMP_OFFSET = 16'd4500;
  localparam logic [13:0] HUM_SPAN    = 14'd10000;

  // status bits
  localparam int STATUS_TEMP_BAD = 0;
  localparam int STATUS_HUM_BAD  = 1;

  // one completed frame, before conversion
  typedef struct packed {
    logic [15:0] raw_temperature;
    logic [15:0] raw_humidity;
    logic [1:0]  status;
  } frame_t;

  // one crc-8 byte update, msb first
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: rtl/htfd_in_if.sv
// ----------------------------------------------------------------------------
// htfd_in_if
// Byte channel into the decoder: valid/ready handshake plus one byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface htfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;

  modport source (output valid, output data_byte, output frame_start, input ready);
  modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

`default_nettype wire

// File: rtl/htfd_out_if.sv
// ----------------------------------------------------------------------------
// htfd_out_if
// Result channel out of the decoder: valid/ready handshake plus one result.
// ----------------------------------------------------------------------------
`default_nettype none

interface htfd_out_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] temp_centi;
  logic        [13:0] humid_centi;
  logic        [1:0]  status;

  modport source (output valid, output temp_centi, output humid_centi, output status,
                  input ready);
  modport sink   (input valid, input temp_centi, input humid_centi, input status,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/humidity_temp_frame_decoder_core.sv
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder_core
// Decodes six-byte temperature/humidity frames with per-word crc-8 checks.
// ----------------------------------------------------------------------------
// Path: a frame is registered in htfd_parse, then its result in htfd_conv.
// Throughput: one byte per cycle; the whole pipeline stalls only while a
//   result waits at the output and is not taken.
// Reset: synchronous, active high; clears position, crc and valid flags, and
//   the next byte is taken as the first of a frame.
`default_nettype none

module humidity_temp_frame_decoder_core import htfd_pkg::*; (
  input wire logic  clk,
  input wire logic  rst,
  htfd_in_if.sink   in_ch,
  htfd_out_if.source out_ch
);

  logic   advance;
  logic   accept;
  logic   frame_valid;
  frame_t frame;

  // pipeline moves whenever the result register is free or being drained
  assign advance     = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = advance;
  assign accept      = in_ch.valid && advance;

  htfd_parse u_parse (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .accept      (accept),
    .data_byte   (in_ch.data_byte),
    .frame_start (in_ch.frame_start),
    .frame_valid (frame_valid),
    .frame       (frame)
  );

  htfd_conv u_conv (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .frame_valid (frame_valid),
    .frame       (frame),
    .out_valid   (out_ch.valid),
    .temp_centi  (out_ch.temp_centi),
    .humid_centi (out_ch.humid_centi),
    .status      (out_ch.status)
  );

endmodule

`default_nettype wire

// File: rtl/htfd_parse.sv
// ----------------------------------------------------------------------------
// htfd_parse
// Frame parser: tracks the byte position, runs the per-word crc and
// registers one frame when its last byte arrives.
// ----------------------------------------------------------------------------
`default_nettype none

module htfd_parse import htfd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       advance,
  input  wire logic       accept,
  input  wire logic [7:0] data_byte,
  input  wire logic       frame_start,
  output logic            frame_valid,
  output frame_t          frame
);

  logic [2:0]  byte_position;
  logic [7:0]  crc_accumulator;
  logic [15:0] raw_temperature;
  logic [15:0] raw_humidity;
  logic        temp_crc_bad;
  logic [2:0]  pos_eff;
  logic        last_byte;

  // restart on a start mark or an unused position
  assign pos_eff = (frame_start || byte_position > POS_HUM_CRC) ? POS_TEMP_MSB : byte_position;
  assign last_byte = (pos_eff == POS_HUM_CRC);

  // per-byte state update
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= POS_TEMP_MSB;
      crc_accumulator <= CRC_INIT;
      raw_temperature <= '0;
      raw_humidity    <= '0;
      temp_crc_bad    <= 1'b0;
    end else if (accept) begin
      byte_position <= pos_eff + 3'd1;
      case (pos_eff)
        POS_TEMP_MSB: begin
          crc_accumulator       <= crc8_update(CRC_INIT, data_byte);
          raw_temperature[15:8] <= data_byte;
        end
        POS_TEMP_LSB: begin
          crc_accumulator      <= crc8_update(crc_accumulator, data_byte);
          raw_temperature[7:0] <= data_byte;
        end
        POS_TEMP_CRC: begin
          temp_crc_bad    <= (crc_accumulator != data_byte);
          crc_accumulator <= CRC_INIT;
        end
        POS_HUM_MSB: begin
          crc_accumulator    <= crc8_update(CRC_INIT, data_byte);
          raw_humidity[15:8] <= data_byte;
        end
        POS_HUM_LSB: begin
          crc_accumulator   <= crc8_update(crc_accumulator, data_byte);
          raw_humidity[7:0] <= data_byte;
        end
        default: begin
          crc_accumulator <= CRC_INIT;
          byte_position   <= POS_TEMP_MSB;
        end
      endcase
    end
  end

  // completed frame register
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (advance) begin
      frame_valid <= accept && last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && accept && last_byte) begin
      frame.raw_temperature         <= raw_temperature;
      frame.raw_humidity            <= raw_humidity;
      frame.status[STATUS_TEMP_BAD] <= temp_crc_bad;
      frame.status[STATUS_HUM_BAD]  <= (crc_accumulator != data_byte);
    end
  end

endmodule

`default_nettype wire

// File: rtl/htfd_conv.sv
// ----------------------------------------------------------------------------
// htfd_conv
// Conversion stage: scales the raw words to hundredths and holds the
// result register of the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module htfd_conv import htfd_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          advance,
  input  wire logic          frame_valid,
  input  wire frame_t        frame,
  output logic               out_valid,
  output logic signed [14:0] temp_centi,
  output logic        [13:0] humid_centi,
  output logic        [1:0]  status
);

  // floor(x / 65535): take x >> 16, then correct once with the remainder
  function automatic logic [15:0] div_by_65535(input logic [30:0] x);
    logic [14:0] q0;
    logic [16:0] r0;
    q0 = x[30:16];
    r0 = {1'b0, x[15:0]} + {2'b00, q0};
    return {1'b0, q0} + {15'd0, (r0 >= 17'd65535)};
  endfunction

  logic [30:0] temp_prod;
  logic [30:0] hum_prod;
  logic [15:0] temp_q;
  logic [15:0] hum_q;
  logic [15:0] temp_shift;

  // constant multiply and divide
  assign temp_prod  = {16'd0, TEMP_SPAN} * {15'd0, frame.raw_temperature};
  assign hum_prod   = {17'd0, HUM_SPAN} * {15'd0, frame.raw_humidity};
  assign temp_q     = div_by_65535(temp_prod);
  assign hum_q      = div_by_65535(hum_prod);
  assign temp_shift = temp_q - TEMP_OFFSET;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= frame_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && frame_valid) begin
      temp_centi  <= signed'(temp_shift[14:0]);
      humid_centi <= hum_q[13:0];
      status      <= frame.status;
    end
  end

endmodule

`default_nettype wire

// File: tb/tb_humidity_temp_frame_decoder_core.sv
// ----------------------------------------------------------------------------
// tb_humidity_temp_frame_decoder_core
// Streams six-byte measurement frames into the decoder and checks every
// reading against a cycle-free decoder model kept in the testbench. Frames
// come well formed, with bad check bytes, cut short by a restart, or without
// a start mark. Sender gaps and receiver stalls vary by phase, and one long
// receiver hold-off backs the pipeline up into the byte input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_humidity_temp_frame_decoder_core;
  import htfd_pkg::*;

  localparam int RAW_FULL_SCALE = 65535;
  localparam int ITEMS_PER_PHASE = 113;
  localparam int HOLD_CYCLES = 200;
  localparam int DRAIN_CYCLES = 10;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } frame_byte_t;

  typedef struct {
    logic signed [14:0] temp;
    logic        [13:0] humid;
    logic        [1:0]  status;
  } reading_t;

  logic clk = 1'b0;
  logic rst;

  htfd_in_if  byte_bus ();
  htfd_out_if reading_bus ();

  humidity_temp_frame_decoder_core u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (byte_bus),
    .out_ch (reading_bus)
  );

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  frame_byte_t pending_bytes[$];
  reading_t    expected_readings[$];
  int          errors = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  logic        hold_trigger = 1'b0;

  // decoder model state
  logic [2:0]  dec_pos;
  logic [7:0]  dec_crc;
  logic [15:0] dec_raw_temp;
  logic [15:0] dec_raw_hum;
  logic        dec_temp_bad;

  // crc-8, bit-serial form
  function automatic logic [7:0] crc_step(input logic [7:0] acc, input logic [7:0] b);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb  = acc[7] ^ b[i];
      acc = {acc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return acc;
  endfunction

  function automatic logic [7:0] word_crc(input logic [15:0] w);
    return crc_step(crc_step(CRC_INIT, w[15:8]), w[7:0]);
  endfunction

  // advance the decoder model by one byte, queue a reading on a full frame
  task automatic decode_byte(input frame_byte_t fb);
    logic [2:0]  p;
    longint      tq;
    longint      hq;
    reading_t    r;
    p = (fb.start || dec_pos > POS_HUM_CRC) ? POS_TEMP_MSB : dec_pos;
    case (p)
      POS_TEMP_MSB: begin
        dec_crc = crc_step(CRC_INIT, fb.data);
        dec_raw_temp[15:8] = fb.data;
      end
      POS_TEMP_LSB: begin
        dec_crc = crc_step(dec_crc, fb.data);
        dec_raw_temp[7:0] = fb.data;
      end
      POS_TEMP_CRC: begin
        dec_temp_bad = (dec_crc != fb.data);
        dec_crc = CRC_INIT;
      end
      POS_HUM_MSB: begin
        dec_crc = crc_step(CRC_INIT, fb.data);
        dec_raw_hum[15:8] = fb.data;
      end
      POS_HUM_LSB: begin
        dec_crc = crc_step(dec_crc, fb.data);
        dec_raw_hum[7:0] = fb.data;
      end
      default: begin
        tq = (longint'(TEMP_SPAN) * longint'(dec_raw_temp)) / RAW_FULL_SCALE;
        hq = (longint'(HUM_SPAN) * longint'(dec_raw_hum)) / RAW_FULL_SCALE;
        r.temp  = 15'(tq - longint'(TEMP_OFFSET));
        r.humid = 14'(hq);
        r.status = 2'b00;
        r.status[STATUS_TEMP_BAD] = dec_temp_bad;
        r.status[STATUS_HUM_BAD]  = (dec_crc != fb.data);
        expected_readings.push_back(r);
        dec_crc = CRC_INIT;
      end
    endcase
    dec_pos = (p == POS_HUM_CRC) ? POS_TEMP_MSB : p + 3'd1;
  endtask

  task automatic add_byte(input logic [7:0] data, input logic start);
    frame_byte_t fb;
    fb.data  = data;
    fb.start = start;
    pending_bytes.push_back(fb);
  endtask

  // one frame; a bad word gets its check byte flipped by a nonzero mask
  task automatic add_frame(input logic [15:0] raw_t, input logic [15:0] raw_h,
                           input logic bad_t, input logic bad_h, input logic mark);
    logic [7:0] crc_t;
    logic [7:0] crc_h;
    crc_t = word_crc(raw_t) ^ (bad_t ? 8'($urandom_range(1, 255)) : 8'h00);
    crc_h = word_crc(raw_h) ^ (bad_h ? 8'($urandom_range(1, 255)) : 8'h00);
    add_byte(raw_t[15:8], mark);
    add_byte(raw_t[7:0], 1'b0);
    add_byte(crc_t, 1'b0);
    add_byte(raw_h[15:8], 1'b0);
    add_byte(raw_h[7:0], 1'b0);
    add_byte(crc_h, 1'b0);
  endtask

  function automatic logic [15:0] pick_raw();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 16'h0000;
    if (r < 20) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  // mostly well-formed frames, some cut short by a restart, some stray bytes
  task automatic add_random_items(input int n);
    int added;
    int r;
    int k;
    added = 0;
    while (added < n) begin
      r = $urandom_range(99);
      if (r < 78) begin
        add_frame(pick_raw(), pick_raw(), $urandom_range(99) < 15,
                  $urandom_range(99) < 15, 1'($urandom_range(1)));
        added += 6;
      end else if (r < 90) begin
        k = $urandom_range(1, 5);
        for (int i = 0; i < k; i++) begin
          add_byte(8'($urandom), (i == 0) ? 1'($urandom_range(1)) : 1'b0);
        end
        add_frame(pick_raw(), pick_raw(), $urandom_range(99) < 15,
                  $urandom_range(99) < 15, 1'b1);
        added += k + 6;
      end else begin
        add_byte(8'($urandom), 1'($urandom_range(1)));
        added += 1;
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() != 0 || expected_readings.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // byte driver
  always @(posedge clk) begin : byte_driver
    logic took;
    took = byte_bus.valid && byte_bus.ready;
    if (rst) begin
      byte_bus.valid       <= 1'b0;
      byte_bus.data_byte   <= 8'h00;
      byte_bus.frame_start <= 1'b0;
    end else begin
      if (took) begin
        decode_byte(pending_bytes.pop_front());
      end
      if (!byte_bus.valid || took) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          byte_bus.valid       <= 1'b1;
          byte_bus.data_byte   <= pending_bytes[0].data;
          byte_bus.frame_start <= pending_bytes[0].start;
        end else begin
          byte_bus.valid <= 1'b0;
        end
      end
    end
  end

  // reading monitor and receiver backpressure
  logic hold_seen = 1'b0;
  int   hold_left = 0;

  always @(posedge clk) begin : reading_monitor
    reading_t want;
    if (rst) begin
      reading_bus.ready <= 1'b0;
    end else begin
      if (reading_bus.valid && reading_bus.ready) begin
        if (expected_readings.size() == 0) begin
          $display("%0t: unexpected reading temp %0d humid %0d status %0d", $time,
                   reading_bus.temp_centi, reading_bus.humid_centi, reading_bus.status);
          errors++;
        end else begin
          want = expected_readings.pop_front();
          if (reading_bus.temp_centi !== want.temp || reading_bus.humid_centi !== want.humid
              || reading_bus.status !== want.status) begin
            $display("%0t: mismatch expected temp %0d humid %0d status %0d, got %0d %0d %0d",
                     $time, want.temp, want.humid, want.status, reading_bus.temp_centi,
                     reading_bus.humid_centi, reading_bus.status);
            errors++;
          end
        end
      end
      if (hold_trigger != hold_seen) begin
        hold_seen = hold_trigger;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        reading_bus.ready <= 1'b0;
      end else begin
        reading_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // watchdog on cycles with no handshake
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if ((byte_bus.valid && byte_bus.ready) || (reading_bus.valid && reading_bus.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // stimulus sequence
  int send_pcts[4] = '{0, 76, 0, 29};
  int recv_pcts[4] = '{0, 0, 76, 29};

  initial begin
    byte_bus.valid       = 1'b0;
    byte_bus.data_byte   = 8'h00;
    byte_bus.frame_start = 1'b0;
    reading_bus.ready    = 1'b0;
    dec_pos      = POS_TEMP_MSB;
    dec_crc      = CRC_INIT;
    dec_raw_temp = 16'h0000;
    dec_raw_hum  = 16'h0000;
    dec_temp_bad = 1'b0;
    rst = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // lowest readings, all checks good
    add_frame(16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1);
    // highest readings without a start mark, temperature check bad
    add_frame(16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 1'b0);
    // partial frame dropped by a restart, then both checks bad
    add_byte(8'hFF, 1'b1);
    add_byte(8'h00, 1'b0);
    add_frame(16'h6666, 16'h8000, 1'b1, 1'b1, 1'b1);
    // humidity check bad, no start mark
    add_frame(16'hBEEF, 16'h1234, 1'b0, 1'b1, 1'b0);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      @(negedge clk);
      send_idle_pct  = send_pcts[ph];
      recv_stall_pct = recv_pcts[ph];
      // long receiver hold-off while bytes keep coming
      if (ph == 0) begin
        hold_trigger = ~hold_trigger;
      end
      add_random_items(ITEMS_PER_PHASE);
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0 && expected_readings.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
